// File: hw/rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the rotor substitution stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

    // Alphabet size and derived widths
    localparam int LETTER_COUNT = 26;
    localparam int LETTER_W     = 5;
    localparam int IDX_W        = $clog2(LETTER_COUNT);
    localparam int STEP_W       = 10;
    localparam int STEP_LIMIT   = LETTER_COUNT * LETTER_COUNT;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int SLOT_W = 2;

    // Register indexes (byte address / 4)
    localparam logic REG_ROTOR_SLOT = 1'b0;

    // Rotor slot codes; any other code turns once every STEP_LIMIT reverse items
    localparam logic [SLOT_W-1:0] SLOT_FAST   = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_MIDDLE = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_RESET  = SLOT_FAST;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_REV  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          kind;
        logic [LETTER_W-1:0] position;
        logic [LETTER_W-1:0] letter;
    } t_in_item;

    typedef struct packed {
        logic [LETTER_W-1:0] result_letter;
        logic                turned;
    } t_out_item;

endpackage

`default_nettype wire

// File: hw/rtl/rotor_substitution_stepper_top.sv
// ----------------------------------------------------------------------------
// rotor_substitution_stepper_top
// One cipher rotor: a loadable wiring table that turns like a ring.
// ----------------------------------------------------------------------------
// A load transaction writes one wiring entry and sends the rotor home; a
// forward transaction maps a letter through the rotated table; a reverse
// transaction returns the first rotated position holding the letter (or the
// letter itself when none does) and then steps the rotor according to the
// rotor_slot register (slot 1 every reverse, slot 2 every 26, else every 676).
// Every transaction returns exactly one result. The wiring lives in a single
// 26-entry synchronous RAM with a registered read port. A reverse transaction
// walks the RAM one entry per cycle through that single read port, from rotated
// position zero up to the first match or, when nothing matches, position 25.
// The input is taken only while no transaction is in flight, but a finished
// result may still be waiting in the output register when the next one is
// accepted. Wiring entries read before they were ever loaded return arbitrary
// data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotor_substitution_stepper_top
    import rss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    // Item input channel
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire t_in_item          i_in_data,

    // Result output channel
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      t_out_item         o_out_data,

    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready
);

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    logic [SLOT_W-1:0] r_slot;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_ROTOR_SLOT)) begin
            r_slot <= pwdata[SLOT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ROTOR_SLOT) begin
            prdata[SLOT_W-1:0] = r_slot;
        end
    end

    // ------------------------------------------------------------------------
    // Wiring RAM: one write port, one registered read port
    // ------------------------------------------------------------------------
    logic [LETTER_W-1:0] r_wiring [LETTER_COUNT];
    logic [LETTER_W-1:0] r_rd_data;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [LETTER_W-1:0] mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wiring[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_wiring[mem_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // Control and rotor state
    // ------------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_offset, n_offset;
    logic [STEP_W-1:0]   r_count, n_count;
    logic [LETTER_W-1:0] r_letter, n_letter;   // letter under reverse search
    logic [IDX_W-1:0]    r_idx, n_idx;         // rotated position of r_rd_data
    logic [IDX_W-1:0]    r_addr, n_addr;       // physical address of r_rd_data
    logic [LETTER_W-1:0] r_res, n_res;         // parked result for ST_DONE
    logic                r_turn, n_turn;

    // Output register
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_data, n_out_data;

    logic                in_acc;
    logic                out_free;
    logic                scan_hit;
    logic                scan_end;

    // Helpers
    logic [IDX_W-1:0]    fwd_idx;
    logic [IDX_W:0]      fwd_sum;
    logic [IDX_W-1:0]    fwd_addr;
    logic [IDX_W-1:0]    scan_next;
    logic [IDX_W-1:0]    offset_inc;
    logic [STEP_W-1:0]   count_inc;
    logic [IDX_W-1:0]    step_offset;
    logic [STEP_W-1:0]   step_count;
    logic                step_turn;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign scan_hit = (r_rd_data == r_letter);
    assign scan_end = (r_idx == IDX_W'(LETTER_COUNT - 1));

    // Forward index: out-of-range letters read position zero
    assign fwd_idx  = ({1'b0, i_in_data.letter} < (LETTER_W + 1)'(LETTER_COUNT))
                      ? IDX_W'(i_in_data.letter) : '0;
    assign fwd_sum  = {1'b0, fwd_idx} + {1'b0, r_offset};
    assign fwd_addr = (fwd_sum >= (IDX_W + 1)'(LETTER_COUNT))
                      ? IDX_W'(fwd_sum - (IDX_W + 1)'(LETTER_COUNT))
                      : IDX_W'(fwd_sum);

    assign scan_next  = (r_addr == IDX_W'(LETTER_COUNT - 1)) ? '0 : r_addr + 1'b1;
    assign offset_inc = (r_offset == IDX_W'(LETTER_COUNT - 1)) ? '0 : r_offset + 1'b1;
    assign count_inc  = r_count + 1'b1;

    // Stepping rule applied at the end of a reverse transaction
    always_comb begin
        step_offset = r_offset;
        step_count  = count_inc;
        step_turn   = 1'b0;
        if (r_slot == SLOT_FAST) begin
            // Fast rotor turns every time and leaves the count alone
            step_offset = offset_inc;
            step_count  = r_count;
            step_turn   = 1'b1;
        end else if ((r_slot == SLOT_MIDDLE) &&
                     (count_inc >= STEP_W'(LETTER_COUNT))) begin
            step_offset = offset_inc;
            step_count  = '0;
            step_turn   = 1'b1;
        end else if (count_inc >= STEP_W'(STEP_LIMIT)) begin
            step_offset = offset_inc;
            step_count  = '0;
            step_turn   = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.kind)
                        KIND_FWD: n_state = ST_FWD;
                        KIND_REV: n_state = ST_SCAN;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_FWD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------------
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = IDX_W'(i_in_data.position);
        mem_wdata   = i_in_data.letter;
        mem_re      = 1'b0;
        mem_raddr   = fwd_addr;
        n_offset    = r_offset;
        n_count     = r_count;
        n_letter    = r_letter;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_res       = r_res;
        n_turn      = r_turn;
        n_out_data  = r_out_data;
        // Drop the result once the far side has taken it
        n_out_valid = r_out_valid & i_out_stall;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res  = '0;
                    n_turn = 1'b0;
                    case (i_in_data.kind)
                        KIND_LOAD: begin
                            // Ignore out-of-range positions, still send rotor home
                            mem_we   = ({1'b0, i_in_data.position} <
                                        (LETTER_W + 1)'(LETTER_COUNT));
                            n_offset = '0;
                            n_count  = '0;
                        end
                        KIND_FWD: begin
                            mem_re    = 1'b1;
                            mem_raddr = fwd_addr;
                        end
                        KIND_REV: begin
                            // Start the walk at rotated position zero
                            mem_re    = 1'b1;
                            mem_raddr = r_offset;
                            n_letter  = i_in_data.letter;
                            n_idx     = '0;
                            n_addr    = r_offset;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FWD: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.result_letter = r_rd_data;
                    n_out_data.turned        = 1'b0;
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_end) begin
                    n_res    = scan_hit ? LETTER_W'(r_idx) : r_letter;
                    n_turn   = step_turn;
                    n_offset = step_offset;
                    n_count  = step_count;
                end else begin
                    // Advance to the next rotated position
                    mem_re    = 1'b1;
                    mem_raddr = scan_next;
                    n_addr    = scan_next;
                    n_idx     = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.result_letter = r_res;
                    n_out_data.turned        = r_turn;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_offset    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_offset    <= n_offset;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_letter   <= n_letter;
        r_idx      <= n_idx;
        r_addr     <= n_addr;
        r_res      <= n_res;
        r_turn     <= n_turn;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire
